/* hdl/source_hit_counter_alert_table_assert.svh */
// assertion macros for the source hit counter alert table
// expects clk and rst_n in the scope of each use
`ifndef SOURCE_HIT_COUNTER_ALERT_TABLE_ASSERT_SVH
`define SOURCE_HIT_COUNTER_ALERT_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define SHCAT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shcat assertion failed");
`define SHCAT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shcat assertion failed");
`else
`define SHCAT_ASSERT_IMP(lbl, ante, cons)
`define SHCAT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* hdl/shcat_pkg.sv */
// shared constants and types for the source hit counter alert table
// no dependencies
`default_nettype none
package shcat_pkg;
    localparam int TABLE_ENTRIES   = 32;
    localparam int IDX_W           = $clog2(TABLE_ENTRIES);
    localparam int CNT_W           = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W          = 32;
    localparam int PORT_W          = 16;
    localparam int HIT_W           = 16;
    localparam int ENTRY_W         = ADDR_W + HIT_W;
    localparam logic [HIT_W-1:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [HIT_W-1:0] THRESHOLD_RESET = 16'd10;
    localparam logic REG_ALERT_THRESHOLD = 1'b0;

    typedef enum logic [1:0] {
        OUTCOME_MATCH = 2'd0,
        OUTCOME_NEW   = 2'd1,
        OUTCOME_DROP  = 2'd2
    } outcome_t;
endpackage
`default_nettype wire

/* hdl/shcat_ram.sv */
// generic single-write single-read ram with registered read data
// no dependencies
`default_nettype none
module shcat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

/* hdl/source_hit_counter_alert_table.sv */
// top level of the source hit counter alert table
// depends on shcat_pkg, shcat_ram and source_hit_counter_alert_table_assert.svh
//
// usage:
// s_* carries probe items (source address, destination port); m_* carries one
// result item per probe (alert, hit count, alert port in tdata, outcome in tuser).
// the apb port holds alert_threshold at byte address 0; write it only while idle.
// a probe is matched by scanning the table in one memory, one entry per cycle,
// lowest index first, with the compare in the cycle after the read. a match or a
// new entry is written back in the cycle of the decision.
// a result follows the scan, which stops at the matching entry or after the last
// used entry (used = entries in the table); on an empty table the scan is skipped.
// the scan length through the single memory read port sets the rate, and a new
// probe is accepted only after the previous result has left the scan sequencer.
// a result waits in an output register while the receiver stalls; the next
// probe is accepted meanwhile, but its result is held until that register frees.
// reset empties the table (used_reg to zero), sets the threshold to 10 and
// drops any pending result; memory contents are not cleared.
`default_nettype none
`include "source_hit_counter_alert_table_assert.svh"
module source_hit_counter_alert_table
    import shcat_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // source_address[31:0], probe_port[47:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // alert[0], hit_count[16:1], alert_port[32:17], zero
    output logic      [1:0]  m_tuser,   // outcome[1:0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   key_reg, key_next;
    logic [PORT_W-1:0]   port_reg, port_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [HIT_W-1:0]    thr_reg, thr_next;
    logic                res_alert_reg, res_alert_next;
    logic [HIT_W-1:0]    res_count_reg, res_count_next;
    outcome_t            res_outcome_reg, res_outcome_next;
    logic [PORT_W-1:0]   res_port_reg, res_port_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_alert_reg, out_alert_next;
    logic [HIT_W-1:0]    out_count_reg, out_count_next;
    outcome_t            out_outcome_reg, out_outcome_next;
    logic [PORT_W-1:0]   out_port_reg, out_port_next;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic                rd_en;
    logic [ENTRY_W-1:0]  rd_data;

    logic                match;
    logic [HIT_W-1:0]    old_cnt;
    logic [HIT_W-1:0]    inc_cnt;
    logic                inc_alert;
    logic [IDX_W-1:0]    last_idx;
    logic                full;
    logic                cfg_wr;

    shcat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    assign rd_en     = (state_reg == ST_SCAN);
    assign match     = (rd_data[ADDR_W-1:0] == key_reg);
    assign old_cnt   = rd_data[ENTRY_W-1:ADDR_W];
    assign inc_cnt   = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + HIT_W'(1);
    assign inc_alert = (inc_cnt >= thr_reg);
    assign last_idx  = IDX_W'(used_reg - CNT_W'(1));
    assign full      = (used_reg == CNT_W'(TABLE_ENTRIES));

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ALERT_THRESHOLD) ? {16'b0, thr_reg} : 32'b0;

    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_wr && (paddr[2] == REG_ALERT_THRESHOLD))
        begin
            thr_next = pwdata[HIT_W-1:0];
        end
    end

    // scan sequencer
    always_comb
    begin
        state_next       = state_reg;
        key_next         = key_reg;
        port_next        = port_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_idx_next     = cmp_idx_reg;
        cmp_vld_next     = cmp_vld_reg;
        used_next        = used_reg;
        res_alert_next   = res_alert_reg;
        res_count_next   = res_count_reg;
        res_outcome_next = res_outcome_reg;
        res_port_next    = res_port_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_alert_next   = out_alert_reg;
        out_count_next   = out_count_reg;
        out_outcome_next = out_outcome_reg;
        out_port_next    = out_port_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    key_next     = s_tdata[ADDR_W-1:0];
                    port_next    = s_tdata[ADDR_W+PORT_W-1:ADDR_W];
                    rd_idx_next  = '0;
                    cmp_vld_next = 1'b0;
                    if (used_reg == '0)
                    begin
                        wr_en            = 1'b1;
                        wr_addr          = '0;
                        wr_data          = {HIT_W'(1), s_tdata[ADDR_W-1:0]};
                        used_next        = CNT_W'(1);
                        res_alert_next   = 1'b0;
                        res_count_next   = HIT_W'(1);
                        res_outcome_next = OUTCOME_NEW;
                        res_port_next    = '0;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_idx_next  = rd_idx_reg + IDX_W'(1);
                cmp_idx_next = rd_idx_reg;
                cmp_vld_next = 1'b1;
                if (cmp_vld_reg)
                begin
                    if (match)
                    begin
                        wr_en            = 1'b1;
                        wr_addr          = cmp_idx_reg;
                        wr_data          = {inc_cnt, key_reg};
                        res_alert_next   = inc_alert;
                        res_count_next   = inc_cnt;
                        res_outcome_next = OUTCOME_MATCH;
                        res_port_next    = inc_alert ? port_reg : '0;
                        state_next       = ST_DONE;
                    end
                    else if (cmp_idx_reg == last_idx)
                    begin
                        res_alert_next = 1'b0;
                        res_port_next  = '0;
                        state_next     = ST_DONE;
                        if (full)
                        begin
                            res_count_next   = '0;
                            res_outcome_next = OUTCOME_DROP;
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            wr_addr          = used_reg[IDX_W-1:0];
                            wr_data          = {HIT_W'(1), key_reg};
                            used_next        = used_reg + CNT_W'(1);
                            res_count_next   = HIT_W'(1);
                            res_outcome_next = OUTCOME_NEW;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_alert_next   = res_alert_reg;
                    out_count_next   = res_count_reg;
                    out_outcome_next = res_outcome_reg;
                    out_port_next    = res_port_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_vld_reg   <= 1'b0;
            used_reg      <= '0;
            thr_reg       <= THRESHOLD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_vld_reg   <= cmp_vld_next;
            used_reg      <= used_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        port_reg        <= port_next;
        rd_idx_reg      <= rd_idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        res_alert_reg   <= res_alert_next;
        res_count_reg   <= res_count_next;
        res_outcome_reg <= res_outcome_next;
        res_port_reg    <= res_port_next;
        out_alert_reg   <= out_alert_next;
        out_count_reg   <= out_count_next;
        out_outcome_reg <= out_outcome_next;
        out_port_reg    <= out_port_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_port_reg, out_count_reg, out_alert_reg};
    assign m_tuser  = out_outcome_reg;

    `SHCAT_ASSERT_IMP(a_used_range, 1'b1, used_reg <= CNT_W'(TABLE_ENTRIES))
    `SHCAT_ASSERT_IMP(a_drop_fields, m_tvalid && (m_tuser == OUTCOME_DROP),
        (m_tdata[16:0] == 17'b0) && (m_tdata[32:17] == 16'b0))
    `SHCAT_ASSERT_IMP(a_alert_on_match, m_tvalid && m_tdata[0], m_tuser == OUTCOME_MATCH)
    `SHCAT_ASSERT_NXT(a_used_step, state_reg == ST_IDLE,
        (used_reg == $past(used_reg)) || (used_reg == $past(used_reg) + CNT_W'(1)))
endmodule
`default_nettype wire

/* bench/probe_result_checker.sv */
`timescale 1ns / 1ps
// scoreboard for the source hit counter alert table: watches the probe, result and apb
// ports, keeps its own copy of the source table and threshold, checks results in order
// depends on shcat_pkg
module probe_result_checker
    import shcat_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,   // source_address[31:0], probe_port[47:32]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,   // alert[0], hit_count[16:1], alert_port[32:17], zero
    input  wire logic [1:0]  m_tuser,   // outcome[1:0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic [31:0] prdata,
    input  wire logic        pready,
    output int               mismatches,
    output int               outstanding
);
    localparam logic [2:0] THRESHOLD_ADDR = {REG_ALERT_THRESHOLD, 2'b00};
    localparam int MAX_SHOWN = 40;

    typedef struct packed {
        logic              alert;
        logic [HIT_W-1:0]  hits;
        outcome_t          outcome;
        logic [PORT_W-1:0] port;
    } probe_result_t;

    logic [ADDR_W-1:0] known_src [TABLE_ENTRIES];
    logic [HIT_W-1:0]  src_hits [TABLE_ENTRIES];
    int                entries_filled;
    logic [HIT_W-1:0]  threshold;
    probe_result_t     expected_results [$];
    int                shown;

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        if (shown < MAX_SHOWN)
        begin
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        shown++;
        mismatches++;
    endtask

    task automatic score_probe(input logic [ADDR_W-1:0] src, input logic [PORT_W-1:0] dport,
                               output probe_result_t r);
        int               hit_idx;
        logic [HIT_W-1:0] c;
        hit_idx = -1;
        r = '0;
        for (int i = 0; i < entries_filled; i++)
        begin
            if (hit_idx < 0 && known_src[i] == src)
            begin
                hit_idx = i;
            end
        end
        if (hit_idx >= 0)
        begin
            c = src_hits[hit_idx];
            if (c != COUNT_MAX)
            begin
                c = c + HIT_W'(1);
            end
            src_hits[hit_idx] = c;
            r.hits = c;
            r.outcome = OUTCOME_MATCH;
            r.alert = (c >= threshold);
            r.port = r.alert ? dport : '0;
        end
        else if (entries_filled < TABLE_ENTRIES)
        begin
            known_src[entries_filled] = src;
            src_hits[entries_filled] = HIT_W'(1);
            entries_filled++;
            r.hits = HIT_W'(1);
            r.outcome = OUTCOME_NEW;
        end
        else
        begin
            r.outcome = OUTCOME_DROP;
        end
    endtask

    always @(posedge clk)
    begin
        probe_result_t want;
        if (!rst_n)
        begin
            entries_filled = 0;
            threshold = THRESHOLD_RESET;
            expected_results.delete();
            mismatches = 0;
            shown = 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with nothing expected", {8'b0, m_tdata}, '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[0] != want.alert)
                        report_mismatch("alert", 48'(m_tdata[0]), 48'(want.alert));
                    if (m_tdata[16:1] != want.hits)
                        report_mismatch("hit_count", 48'(m_tdata[16:1]), 48'(want.hits));
                    if (m_tdata[32:17] != want.port)
                        report_mismatch("alert_port", 48'(m_tdata[32:17]), 48'(want.port));
                    if (m_tdata[39:33] != '0)
                        report_mismatch("tdata padding", 48'(m_tdata[39:33]), '0);
                    if (m_tuser != want.outcome)
                        report_mismatch("outcome", 48'(m_tuser), 48'(want.outcome));
                end
            end
            if (s_tvalid && s_tready)
            begin
                score_probe(s_tdata[31:0], s_tdata[47:32], want);
                expected_results.push_back(want);
            end
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == THRESHOLD_ADDR)
                        threshold = pwdata[HIT_W-1:0];
                end
                else if (paddr == THRESHOLD_ADDR && prdata[HIT_W-1:0] != threshold)
                begin
                    report_mismatch("alert_threshold read", 48'(prdata), 48'(threshold));
                end
            end
            outstanding <= expected_results.size();
        end
    end
endmodule

/* bench/source_hit_counter_alert_table_tb.sv */
`timescale 1ns / 1ps
// testbench top for the source hit counter alert table: drives probes, apb writes and
// result backpressure in phases and gives the verdict
// depends on shcat_pkg, probe_result_checker and the block itself
module source_hit_counter_alert_table_tb;
    import shcat_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 230;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [2:0] THRESHOLD_ADDR = {REG_ALERT_THRESHOLD, 2'b00};
    localparam logic [2:0] SPARE_ADDR     = {~REG_ALERT_THRESHOLD, 2'b00};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          outstanding;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          items_sent = 0;
    int          cycles = 0;
    int          phase_thresholds [RANDOM_PHASES] = '{3, 16, 1, 40, 65535, 25, 8, 12};
    logic [ADDR_W-1:0] table_srcs [$];

    source_hit_counter_alert_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    probe_result_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_probe(input logic [ADDR_W-1:0] src, input logic [PORT_W-1:0] dport);
        bit listed;
        listed = 1'b0;
        foreach (table_srcs[i])
        begin
            if (table_srcs[i] == src)
                listed = 1'b1;
        end
        if (!listed && table_srcs.size() < TABLE_ENTRIES)
            table_srcs.push_back(src);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {dport, src};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_table_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_threshold(input logic [HIT_W-1:0] value);
        wait_table_idle();
        apb_access(1'b1, THRESHOLD_ADDR, {16'b0, value});
        apb_access(1'b0, THRESHOLD_ADDR, '0);
    endtask

    initial
    begin
        int               r;
        logic [ADDR_W-1:0] src;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, alert onset, threshold one, zero and maximum
        apb_access(1'b0, THRESHOLD_ADDR, '0);
        send_probe(32'h0000_0000, 16'h0000);
        send_probe(32'hFFFF_FFFF, 16'hFFFF);
        for (int i = 0; i < 10; i++)
        begin
            send_probe(32'h0000_0000, i[0] ? 16'hFFFF : 16'h8001);
        end
        set_threshold(16'd1);
        send_probe(32'hFFFF_FFFF, 16'h1234);
        send_probe(32'h8000_0001, 16'hABCD);        // new entry never alerts
        set_threshold(16'd0);
        send_probe(32'h8000_0001, 16'h5555);
        wait_table_idle();
        apb_access(1'b1, SPARE_ADDR, 32'h0000_0007);  // unknown register, ignored
        apb_access(1'b0, THRESHOLD_ADDR, '0);
        send_probe(32'h8000_0001, 16'hAAAA);
        set_threshold(COUNT_MAX);
        send_probe(32'hFFFF_FFFF, 16'h0F0F);

        // random: mostly known sources, some fresh or near-miss ones that fill, then drop
        phase_thresholds[6] = $urandom_range(2, 64);
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_threshold(16'(phase_thresholds[ph]));
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 47; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 47; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(99);
                if (r < 75)
                    src = table_srcs[$urandom_range(table_srcs.size() - 1)];
                else if (r < 88)
                    src = table_srcs[$urandom_range(table_srcs.size() - 1)]
                          ^ (32'h1 << $urandom_range(31));
                else
                    src = $urandom;
                send_probe(src, 16'($urandom_range(65535)));
                if ($urandom_range(99) == 0)
                    wait_table_idle();
            end
        end

        // repeated hits on the first entry under receiver stalls
        set_threshold(COUNT_MAX);
        send_idle_pct = 0;
        stall_pct = 40;
        repeat (20) send_probe(table_srcs[0], 16'($urandom_range(65535)));

        wait_table_idle();
        $display("%0d probe items over %0d cycles: table fill and drops, thresholds 0 to 65535,",
                 items_sent, cycles);
        $display("alerts with and without stalls on sender and receiver sides");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

/* files.f */
+incdir+hdl
hdl/shcat_pkg.sv
hdl/shcat_ram.sv
hdl/source_hit_counter_alert_table.sv
bench/probe_result_checker.sv
bench/source_hit_counter_alert_table_tb.sv
